// ===== hw/rtl/tprq_pkg.sv =====
// tprq_pkg: shared types and constants for the task priority ready queue
// command/status structs between controller and datapath, field widths, codes
// depends on nothing
`timescale 1ns / 1ps

package tprq_pkg;

   // fixed field widths on the stream ports
   localparam int CMD_W      = 2;
   localparam int ID_W       = 8;
   localparam int PRIO_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic push_start;
      logic push_step;
      logic push_place;
      logic rmv_start;
      logic rmv_step;
      logic set_miss;
      logic set_full;
      logic load_out;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             empty;
      logic             full;
      logic             shift;
      logic             ptr_last;
      logic             idx_last;
      logic             out_free;
   } ctl_sts_type;

endpackage

// ===== hw/rtl/tprq_ram.sv =====
// tprq_ram: generic single write, single read memory with registered read
// used for the queue entry store; no dependencies
`timescale 1ns / 1ps

module tprq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tprq_datapath.sv =====
// tprq_datapath: entry memory, walk pointers, count, result and output registers
// driven by tprq_ctrl through tprq_pkg command/status structs; uses tprq_ram
`timescale 1ns / 1ps

module tprq_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tprq_pkg::ctl_cmd_type          ctl_cmd,
   output tprq_pkg::ctl_sts_type          ctl_sts,
   input  logic [tprq_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tprq_pkg::ID_W-1:0]      req_id,
   input  logic [tprq_pkg::PRIO_W-1:0]    req_prio,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tprq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tprq_pkg::STATUS_W-1:0]  rsp_tuser
);

   import tprq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = ID_W + PRIO_BITS;

   // control registers
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   // request and walk registers
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [PRIO_BITS-1:0]  prio_ff, prio_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic                  found_ff, found_in;
   // result registers
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic [PRIO_BITS-1:0]  res_prio_ff, res_prio_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   // memory port signals
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;
   logic [AW-1:0]         rd_addr;
   logic [EW-1:0]         rd_data;
   logic [ID_W-1:0]       rd_id;
   logic [PRIO_BITS-1:0]  rd_prio;

   // helpers
   logic [PRIO_BITS+PRIO_W-1:0] req_prio_ext;
   logic [PRIO_BITS+PRIO_W-1:0] res_prio_ext;
   logic [CW+OCC_W-1:0]         cnt_ext;
   logic [CW-1:0]               cnt_m1;
   logic [CW-1:0]               ptr_m1;
   logic [CW-1:0]               ptr_m2;
   logic                        shift;
   logic                        match;
   logic                        idx_last;

   tprq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id   = rd_data[EW-1:PRIO_BITS];
   assign rd_prio = rd_data[PRIO_BITS-1:0];

   // width adaptation of priority and count fields
   assign req_prio_ext = {{PRIO_BITS{1'b0}}, req_prio};
   assign res_prio_ext = {{PRIO_W{1'b0}}, res_prio_ff};
   assign cnt_ext      = {{OCC_W{1'b0}}, cnt_ff};

   // walk arithmetic and compares
   assign cnt_m1   = cnt_ff - CW'(1);
   assign ptr_m1   = ptr_ff - CW'(1);
   assign ptr_m2   = ptr_ff - CW'(2);
   assign shift    = rd_prio > prio_ff;
   assign match    = !found_ff && ((cmd_ff == CMD_POP) || (rd_id == id_ff));
   assign idx_last = CW'(idx_ff) == cnt_m1;

   // status to controller
   always_comb begin
      ctl_sts.cmd      = cmd_ff;
      ctl_sts.empty    = cnt_ff == '0;
      ctl_sts.full     = cnt_ff == CW'(QUEUE_DEPTH);
      ctl_sts.shift    = shift;
      ctl_sts.ptr_last = ptr_ff == CW'(1);
      ctl_sts.idx_last = idx_last;
      ctl_sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   // memory read address
   always_comb begin
      rd_addr = '0;
      priority if (ctl_cmd.push_start) begin
         rd_addr = cnt_m1[AW-1:0];
      end else if (ctl_cmd.push_step) begin
         rd_addr = ptr_m2[AW-1:0];
      end else if (ctl_cmd.rmv_step) begin
         rd_addr = idx_ff + AW'(1);
      end
   end

   // memory write: shift toward tail on push, toward head on remove; also place the new entry on push
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = {id_ff, prio_ff};
      priority if (ctl_cmd.push_step) begin
         wr_en = 1'b1;
         if (shift) begin
            wr_data = rd_data;
         end
      end else if (ctl_cmd.push_place) begin
         wr_en = 1'b1;
      end else if (ctl_cmd.rmv_step) begin
         wr_en   = found_ff;
         wr_addr = idx_ff - AW'(1);
         wr_data = rd_data;
      end
   end

   // next state of the datapath registers
   always_comb begin
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_prio_in   = res_prio_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      // latch the transaction and clear the result
      if (ctl_cmd.capture) begin
         cmd_in        = req_cmd;
         id_in         = req_id;
         prio_in       = req_prio_ext[PRIO_BITS-1:0];
         ptr_in        = cnt_ff;
         res_status_in = STAT_OK;
         res_id_in     = '0;
         res_prio_in   = '0;
      end

      if (ctl_cmd.set_miss) begin
         res_status_in = STAT_MISS;
      end
      if (ctl_cmd.set_full) begin
         res_status_in = STAT_FULL;
      end

      // insertion walk from the tail
      if (ctl_cmd.push_step) begin
         if (shift) begin
            ptr_in = ptr_m1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
      if (ctl_cmd.push_place) begin
         cnt_in = cnt_ff + CW'(1);
      end

      // removal walk from the head
      if (ctl_cmd.rmv_start) begin
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (ctl_cmd.rmv_step) begin
         idx_in = idx_ff + AW'(1);
         if (match) begin
            found_in    = 1'b1;
            res_id_in   = rd_id;
            res_prio_in = rd_prio;
         end
         if (idx_last) begin
            if (found_ff || match) begin
               cnt_in = cnt_m1;
            end else begin
               res_status_in = STAT_MISS;
            end
         end
      end

      // output register
      if (ctl_cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_status_ff;
         rsp_data_in  = {7'b0, cnt_ext[OCC_W-1:0], (cnt_ff == '0),
                         res_prio_ext[PRIO_W-1:0], res_id_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      ptr_ff        <= ptr_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_prio_ff   <= res_prio_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hw/rtl/tprq_ctrl.sv =====
// tprq_ctrl: command sequencer for the ready queue
// issues tprq_pkg::ctl_cmd_type to the datapath from its status struct
`timescale 1ns / 1ps

module tprq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tprq_pkg::ctl_sts_type ctl_sts,
   output tprq_pkg::ctl_cmd_type ctl_cmd
);

   import tprq_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_DECODE     = 6'b000010,
      S_PUSH_WALK  = 6'b000100,
      S_PUSH_PLACE = 6'b001000,
      S_RMV_WALK   = 6'b010000,
      S_FINISH     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      ctl_cmd    = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl_cmd.capture = 1'b1;
               state_in        = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (ctl_sts.cmd)
               CMD_PUSH: begin
                  if (ctl_sts.full) begin
                     ctl_cmd.set_full = 1'b1;
                     state_in         = S_FINISH;
                  end else if (ctl_sts.empty) begin
                     state_in = S_PUSH_PLACE;
                  end else begin
                     ctl_cmd.push_start = 1'b1;
                     state_in           = S_PUSH_WALK;
                  end
               end
               CMD_POP, CMD_REMOVE: begin
                  if (ctl_sts.empty) begin
                     ctl_cmd.set_miss = 1'b1;
                     state_in         = S_FINISH;
                  end else begin
                     ctl_cmd.rmv_start = 1'b1;
                     state_in          = S_RMV_WALK;
                  end
               end
               CMD_NOP: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_PUSH_WALK: begin
            ctl_cmd.push_step = 1'b1;
            if (!ctl_sts.shift) begin
               state_in = S_FINISH;
            end else if (ctl_sts.ptr_last) begin
               state_in = S_PUSH_PLACE;
            end
         end
         S_PUSH_PLACE: begin
            ctl_cmd.push_place = 1'b1;
            state_in           = S_FINISH;
         end
         S_RMV_WALK: begin
            ctl_cmd.rmv_step = 1'b1;
            if (ctl_sts.idx_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (ctl_sts.out_free) begin
               ctl_cmd.load_out = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/task_priority_ready_queue_core.sv =====
// Sequence: a command is accepted in S_IDLE and decoded in S_DECODE, then walks the entries
// of the entry memory one per cycle (up to the occupancy), plus a placement state S_PUSH_PLACE
// for a push that reaches the head; S_FINISH then loads the result register once the output is free.
// One command in flight: the walk over the entry memory is serial, and a new command is not accepted
// until the previous result has been loaded into the output register and the sequencer is back in S_IDLE.
// Reset: synchronous; count and handshakes clear, entry memory is not cleared.
`timescale 1ns / 1ps

module task_priority_ready_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tprq_pkg::REQ_DATA_W-1:0] req_tdata,  // task_id[7:0], priority_req[10:8]
   input  logic [tprq_pkg::CMD_W-1:0]      req_tuser,  // cmd[1:0]
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tprq_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_task_id[7:0], out_priority[10:8],
                                                       // now_empty[11], occupancy[16:12]
   output logic [tprq_pkg::STATUS_W-1:0]   rsp_tuser   // status[1:0]
);

   import tprq_pkg::*;

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   // sequencer
   tprq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ctl_sts    (ctl_sts),
      .ctl_cmd    (ctl_cmd)
   );

   // entry store and result path
   tprq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PRIO_BITS   (PRIO_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl_cmd    (ctl_cmd),
      .ctl_sts    (ctl_sts),
      .req_cmd    (req_tuser),
      .req_id     (req_tdata[ID_W-1:0]),
      .req_prio   (req_tdata[ID_W+PRIO_W-1:ID_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hw/rtl/tprq_checker.sv =====
// tprq_checker: port-level assertions for the ready queue, bound to the top level
// depends on tprq_pkg and task_priority_ready_queue_core
`timescale 1ns / 1ps

module tprq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tprq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [tprq_pkg::STATUS_W-1:0]   rsp_tuser
);

   import tprq_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one command at a time: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while another is in work");

   // failed or refused commands return no entry
   a_fail_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_OK) |-> (rsp_tdata[10:0] == '0))
      else $error("entry reported with failing status");

   // empty flag agrees with occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> (rsp_tdata[16:12] == '0))
      else $error("empty flag with nonzero occupancy");

   // status code is defined
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STAT_OK) || (rsp_tuser == STAT_MISS) ||
                     (rsp_tuser == STAT_FULL))
      else $error("undefined status code");

endmodule

bind task_priority_ready_queue_core tprq_checker u_tprq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
